@@ hdl/ima_adpcm_block_decoder_top_defines.svh @@
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder assertion macros
// Concurrent check wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef IMA_ADPCM_BLOCK_DECODER_TOP_DEFINES_SVH
`define IMA_ADPCM_BLOCK_DECODER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define IMADEC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imadec: check failed");
`define IMADEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imadec: check failed");
`else
`define IMADEC_ASSERT_IMPL(label, ante, cons)
`define IMADEC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hdl/imadec_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder package
// Shared types, constants, the step table and the index deltas.
// ----------------------------------------------------------------------------
package imadec_pkg;

  localparam int CFG_W        = 13;
  localparam int IDX_W        = 7;
  localparam int PCM_W        = 16;
  localparam int SLOT_W       = 13;
  localparam int MAX_CHANNELS = 2;
  localparam int QDEPTH       = 4;
  localparam int QAW          = $clog2(QDEPTH);
  localparam int QCW          = $clog2(QDEPTH + 1);

  localparam logic [IDX_W-1:0]        IDX_MAX = 7'd88;
  localparam logic signed [PCM_W-1:0] PCM_MIN = -16'sd32768;
  localparam logic signed [PCM_W-1:0] PCM_MAX = 16'sd32767;

  localparam logic [1:0] CFG_IDX_CHANNELS = 2'd0;
  localparam logic [1:0] CFG_IDX_BLOCK    = 2'd1;
  localparam logic [1:0] CFG_IDX_SAMPLES  = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_INDEX,
    OP_DECODE
  } op_t;

  typedef struct packed {
    logic [1:0]       num_channels;
    logic [CFG_W-1:0] block_bytes;
    logic [CFG_W-1:0] samples_per_block;
  } cfg_t;

  typedef struct packed {
    op_t               op;
    logic              ch;
    logic [PCM_W-1:0]  data;
    logic [SLOT_W-1:0] slot0;
    logic [SLOT_W-1:0] slot1;
  } cmd_t;

  localparam logic [14:0] STEP_TABLE [89] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14,
    15'd16, 15'd17, 15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31,
    15'd34, 15'd37, 15'd41, 15'd45, 15'd50, 15'd55, 15'd60, 15'd66,
    15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118, 15'd130, 15'd143,
    15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279, 15'd307,
    15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899,
    15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
    15'd32767
  };

  function automatic logic [14:0] step_of(input logic [IDX_W-1:0] idx);
    logic [14:0] s;
    if (idx > IDX_MAX) begin
      s = STEP_TABLE[88];
    end else begin
      s = STEP_TABLE[idx];
    end
    return s;
  endfunction

  function automatic logic signed [4:0] delta_of(input logic [2:0] code);
    logic signed [4:0] d;
    case (code)
      3'd4:    d = 5'sd2;
      3'd5:    d = 5'sd4;
      3'd6:    d = 5'sd6;
      3'd7:    d = 5'sd8;
      default: d = -5'sd1;
    endcase
    return d;
  endfunction

endpackage

@@ hdl/imadec_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder channels
// Valid/ready byte input and sample output channels.
// ----------------------------------------------------------------------------
interface imadec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;

  modport source (output valid, output src_byte, input ready);
  modport sink (input valid, input src_byte, output ready);
endinterface

interface imadec_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_sample;
  logic               chan;
  logic [12:0]        slot;
  logic               last;

  modport source (output valid, output pcm_sample, output chan, output slot,
                  output last, input ready);
  modport sink (input valid, input pcm_sample, input chan, input slot,
                input last, output ready);
endinterface

@@ hdl/imadec_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder front end
// Tracks the block byte position; header and data bytes become commands.
// ----------------------------------------------------------------------------
module imadec_front #(
  parameter int MAX_BLOCK_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  imadec_in_if.sink           in_bus,
  input  imadec_pkg::cfg_t    cfg,
  input  logic                q_full,
  output logic                q_push,
  output imadec_pkg::cmd_t    q_cmd
);

  localparam int PW = $clog2(MAX_BLOCK_BYTES);
  localparam int CW = ((PW > imadec_pkg::CFG_W) ? PW : imadec_pkg::CFG_W) + 1;

  localparam logic [1:0] PART_LOW   = 2'd0;
  localparam logic [1:0] PART_HIGH  = 2'd1;
  localparam logic [1:0] PART_INDEX = 2'd2;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    hdr_low_r, hdr_low_nxt;

  logic          accept;
  logic          stereo;
  logic [CW-1:0] bb_ext, blen, pos_ext, pos_eff, pos_inc, pos_next;
  logic [CW-1:0] hdr, d, grp, groups;
  logic [12:0]   spb_m1, grp13, slot0, slot1;
  logic          chd, chh;
  logic [1:0]    k;
  logic [7:0]    b;
  logic [6:0]    idx7;

  assign in_bus.ready = !q_full;
  assign accept       = in_bus.valid && in_bus.ready;
  assign b            = in_bus.src_byte;

  always_comb begin
    stereo  = (imadec_pkg::MAX_CHANNELS > 1) && (cfg.num_channels >= 2'd2);
    bb_ext  = CW'(cfg.block_bytes);
    if (bb_ext == '0) begin
      blen = CW'(1);
    end else if (bb_ext > CW'(MAX_BLOCK_BYTES)) begin
      blen = CW'(MAX_BLOCK_BYTES);
    end else begin
      blen = bb_ext;
    end
    pos_ext  = CW'(pos_r);
    pos_eff  = (pos_ext >= blen) ? '0 : pos_ext;
    pos_inc  = pos_eff + CW'(1);
    pos_next = (pos_inc >= blen) ? '0 : pos_inc;

    hdr    = stereo ? CW'(8) : CW'(4);
    d      = pos_eff - hdr;
    grp    = stereo ? (d >> 3) : (d >> 2);
    spb_m1 = cfg.samples_per_block - 13'd1;
    groups = (cfg.samples_per_block == '0) ? '0 : CW'(spb_m1 >> 3);
    chd    = stereo & d[2];
    chh    = stereo & pos_eff[2];
    k      = d[1:0];
    grp13  = grp[12:0];
    if (stereo) begin
      slot0 = 13'd2 + {grp13[8:0], 4'b0} + {9'b0, k, 2'b0} + {12'b0, chd};
      slot1 = slot0 + 13'd2;
    end else begin
      slot0 = 13'd1 + {grp13[9:0], 3'b0} + {10'b0, k, 1'b0};
      slot1 = slot0 + 13'd1;
    end
    idx7 = (b > 8'd88) ? imadec_pkg::IDX_MAX : b[6:0];

    q_push      = 1'b0;
    q_cmd.op    = imadec_pkg::OP_LOAD;
    q_cmd.ch    = 1'b0;
    q_cmd.data  = '0;
    q_cmd.slot0 = '0;
    q_cmd.slot1 = '0;
    hdr_low_nxt = hdr_low_r;

    if (pos_eff < hdr) begin
      case (pos_eff[1:0])
        PART_LOW: begin
          if (accept) begin
            hdr_low_nxt = b;
          end
        end
        PART_HIGH: begin
          q_push      = accept;
          q_cmd.op    = imadec_pkg::OP_LOAD;
          q_cmd.ch    = chh;
          q_cmd.data  = {b, hdr_low_r};
          q_cmd.slot0 = {12'b0, chh};
        end
        PART_INDEX: begin
          q_push     = accept;
          q_cmd.op   = imadec_pkg::OP_INDEX;
          q_cmd.ch   = chh;
          q_cmd.data = {9'b0, idx7};
        end
        default: begin
        end
      endcase
    end else if (grp < groups) begin
      q_push      = accept;
      q_cmd.op    = imadec_pkg::OP_DECODE;
      q_cmd.ch    = chd;
      q_cmd.data  = {8'b0, b};
      q_cmd.slot0 = slot0;
      q_cmd.slot1 = slot1;
    end

    pos_nxt = accept ? pos_next[PW-1:0] : pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      hdr_low_r <= '0;
    end else begin
      pos_r     <= pos_nxt;
      hdr_low_r <= hdr_low_nxt;
    end
  end

endmodule

@@ hdl/imadec_cmdq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module imadec_cmdq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  imadec_pkg::cmd_t              wr_cmd,
  input  logic                          pop,
  output imadec_pkg::cmd_t              rd_cmd,
  output logic                          full,
  output logic                          empty,
  output logic [imadec_pkg::QCW-1:0]    count
);

  imadec_pkg::cmd_t             mem_r [imadec_pkg::QDEPTH];
  logic [imadec_pkg::QAW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [imadec_pkg::QCW-1:0]   cnt_r, cnt_nxt;
  logic                         do_push, do_pop;

  assign full   = (cnt_r == imadec_pkg::QCW'(imadec_pkg::QDEPTH));
  assign empty  = (cnt_r == '0);
  assign count  = cnt_r;
  assign rd_cmd = mem_r[rp_r];

  always_comb begin
    do_push = push && !full;
    do_pop  = pop && !empty;
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_cmd;
    end
  end

endmodule

@@ hdl/imadec_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder back end
// Per-channel predictor and step index; one nibble a cycle unless stalled.
// ----------------------------------------------------------------------------
module imadec_back (
  input  logic              clk,
  input  logic              rst_n,
  input  imadec_pkg::cmd_t  q_cmd,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              back_mid,
  imadec_out_if.source      out_bus
);

  localparam logic signed [17:0] VMIN = 18'(imadec_pkg::PCM_MIN);
  localparam logic signed [17:0] VMAX = 18'(imadec_pkg::PCM_MAX);

  logic signed [15:0] pred_r [2];
  logic signed [15:0] pred_nxt [2];
  logic [6:0]         sidx_r [2];
  logic [6:0]         sidx_nxt [2];
  logic               nib_r, nib_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] pcm_r, pcm_nxt;
  logic               chan_r, chan_nxt;
  logic [12:0]        slot_r, slot_nxt;
  logic               last_r, last_nxt;

  logic               ch, out_free, emit;
  logic [3:0]         nib;
  logic [6:0]         idx, nidx;
  logic [14:0]        step;
  logic [18:0]        prod;
  logic [15:0]        mag;
  logic signed [17:0] pred_ext, vsum;
  logic signed [15:0] vsat;
  logic signed [8:0]  nsum;

  assign out_bus.valid      = out_valid_r;
  assign out_bus.pcm_sample = pcm_r;
  assign out_bus.chan       = chan_r;
  assign out_bus.slot       = slot_r;
  assign out_bus.last       = last_r;
  assign back_mid           = nib_r;

  always_comb begin
    ch       = q_cmd.ch;
    out_free = !out_valid_r || out_bus.ready;
    nib      = nib_r ? q_cmd.data[7:4] : q_cmd.data[3:0];
    idx      = sidx_r[ch];
    step     = imadec_pkg::step_of(idx);
    prod     = {4'b0, step} * {15'b0, nib[2:0], 1'b1};
    mag      = prod[18:3];
    pred_ext = 18'(pred_r[ch]);
    vsum     = nib[3] ? pred_ext - $signed({2'b0, mag}) : pred_ext + $signed({2'b0, mag});
    if (vsum < VMIN) begin
      vsat = imadec_pkg::PCM_MIN;
    end else if (vsum > VMAX) begin
      vsat = imadec_pkg::PCM_MAX;
    end else begin
      vsat = vsum[15:0];
    end
    nsum = $signed({2'b0, idx}) + 9'(imadec_pkg::delta_of(nib[2:0]));
    if (nsum < 9'sd0) begin
      nidx = '0;
    end else if (nsum > 9'sd88) begin
      nidx = imadec_pkg::IDX_MAX;
    end else begin
      nidx = nsum[6:0];
    end

    q_pop    = 1'b0;
    emit     = 1'b0;
    nib_nxt  = nib_r;
    pred_nxt = pred_r;
    sidx_nxt = sidx_r;
    pcm_nxt  = pcm_r;
    chan_nxt = chan_r;
    slot_nxt = slot_r;
    last_nxt = last_r;

    if (!q_empty) begin
      case (q_cmd.op)
        imadec_pkg::OP_LOAD: begin
          if (out_free) begin
            emit         = 1'b1;
            q_pop        = 1'b1;
            pred_nxt[ch] = q_cmd.data;
            pcm_nxt      = q_cmd.data;
            chan_nxt     = ch;
            slot_nxt     = q_cmd.slot0;
            last_nxt     = 1'b1;
          end
        end
        imadec_pkg::OP_INDEX: begin
          q_pop        = 1'b1;
          sidx_nxt[ch] = q_cmd.data[6:0];
        end
        imadec_pkg::OP_DECODE: begin
          if (out_free) begin
            emit         = 1'b1;
            q_pop        = nib_r;
            nib_nxt      = !nib_r;
            pred_nxt[ch] = vsat;
            sidx_nxt[ch] = nidx;
            pcm_nxt      = vsat;
            chan_nxt     = ch;
            slot_nxt     = nib_r ? q_cmd.slot1 : q_cmd.slot0;
            last_nxt     = nib_r;
          end
        end
        default: begin
          q_pop = 1'b1;
        end
      endcase
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nib_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pred_r[0]   <= '0;
      pred_r[1]   <= '0;
      sidx_r[0]   <= '0;
      sidx_r[1]   <= '0;
    end else begin
      nib_r       <= nib_nxt;
      out_valid_r <= out_valid_nxt;
      pred_r      <= pred_nxt;
      sidx_r      <= sidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pcm_r  <= pcm_nxt;
    chan_r <= chan_nxt;
    slot_r <= slot_nxt;
    last_r <= last_nxt;
  end

endmodule

@@ hdl/ima_adpcm_block_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder
// Decodes 4-bit IMA ADPCM WAV blocks, one compressed byte per input word.
// ----------------------------------------------------------------------------
// in_bus carries one compressed byte per word; out_bus carries one decoded
// sample per word with its channel, interleaved slot and a last flag on the
// final sample caused by a byte. cfg_we/cfg_idx/cfg_wdata set the channel
// count, block length and samples per block; write them only while idle.
// A header high byte gives one sample, a data byte gives two, all other
// bytes give none. A taken byte is written into the command queue, and its
// first sample is then registered in the output register; the second comes
// from the same byte while it stays at the queue head.
// The single nibble unit in the back end makes one predictor update a
// cycle while the output is free, and a data byte stays at the queue head
// for both nibbles; header and padding bytes go at one a cycle while the
// queue has room. A four-entry command queue sits between front and back.
// Reset clears the block position, both predictors and step indexes, and
// loads mono, 256-byte blocks and 505 samples per block.
// When the receiver stalls the output word holds, the back end waits on
// load and decode commands and input is taken until the command queue fills.
// ----------------------------------------------------------------------------
`include "ima_adpcm_block_decoder_top_defines.svh"

module ima_adpcm_block_decoder_top #(
  parameter int MAX_BLOCK_BYTES = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  imadec_in_if.sink                      in_bus,
  imadec_out_if.source                   out_bus,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_idx,
  input  logic [imadec_pkg::CFG_W-1:0]   cfg_wdata
);

  imadec_pkg::cfg_t            cfg_r, cfg_nxt;
  imadec_pkg::cmd_t            push_cmd, head_cmd;
  logic                        q_push, q_pop, q_full, q_empty, back_mid;
  logic [imadec_pkg::QCW-1:0]  q_count;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        imadec_pkg::CFG_IDX_CHANNELS: cfg_nxt.num_channels      = cfg_wdata[1:0];
        imadec_pkg::CFG_IDX_BLOCK:    cfg_nxt.block_bytes       = cfg_wdata;
        imadec_pkg::CFG_IDX_SAMPLES:  cfg_nxt.samples_per_block = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_channels      <= 2'd1;
      cfg_r.block_bytes       <= 13'd256;
      cfg_r.samples_per_block <= 13'd505;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  imadec_front #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  imadec_cmdq u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (push_cmd),
    .pop    (q_pop),
    .rd_cmd (head_cmd),
    .full   (q_full),
    .empty  (q_empty),
    .count  (q_count)
  );

  imadec_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_cmd    (head_cmd),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .back_mid (back_mid),
    .out_bus  (out_bus)
  );

  `IMADEC_ASSERT_IMPL(a_q_bound, 1'b1, q_count <= imadec_pkg::QCW'(imadec_pkg::QDEPTH))
  `IMADEC_ASSERT_IMPL(a_mid_has_cmd, back_mid, q_count != '0)
  `IMADEC_ASSERT_IMPL(a_first_half_pending, out_bus.valid && !out_bus.last, back_mid)
  `IMADEC_ASSERT_NEXT(a_second_half_follows, out_bus.valid && out_bus.ready && !out_bus.last, out_bus.valid && out_bus.last)

endmodule
